[design/network_coded_xor_decoder_top_assert.svh]
// Assertion macros used by the checker of this block.
`ifndef NETWORK_CODED_XOR_DECODER_TOP_ASSERT_SVH
`define NETWORK_CODED_XOR_DECODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define NCXD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ncxd: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define NCXD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ncxd: next-cycle check failed");

`endif

[design/ncxd_pkg.sv]
package ncxd_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int MAX_FLITS     = 16;
	localparam int NODE_ID_BITS  = 8;
	localparam int FLIT_BYTES    = 4;

	localparam int DATA_W      = 8 * FLIT_BYTES;
	localparam int KEY_W       = 4 * NODE_ID_BITS;
	localparam int SLOT_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
	localparam int LEN_W       = $clog2(MAX_FLITS + 1);
	localparam int STORE_DEPTH = TABLE_ENTRIES * MAX_FLITS;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_TUSER_W = 4;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_FULL      = 2'd1;
	localparam logic [1:0] ERR_NO_ENTRY  = 2'd2;
	localparam logic [1:0] ERR_BEYOND    = 2'd3;

endpackage

[design/network_coded_xor_decoder_top.sv]
// An accepted input word passes the stage-one registers and the RAM read register, then the output register.
// No new flit is taken until the last one's result is in the output register; the table decision and
//   the payload RAM access happen in the accept cycle, the registered RAM read data is combined in the read state.
// Reset (arst_n low, asynchronous): packet table empty, no open match or fill, output empty.
//   Payload RAM and stored keys are not cleared; a word is read only after it was written.
module network_coded_xor_decoder_top
	import ncxd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [7:0] first_source, [15:8] second_source, [23:16] first_dest,
	// [31:24] second_dest, [35:32] flit_index, [67:36] payload_in, [71:68] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] coded, [1] head
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	input  logic                   s_axis_tlast,   // tail
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [31:0] payload_out
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] decoded, [1] stored, [3:2] error_code
	output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	// ---------------- input unpack ----------------
	logic                    coded, head, tail;
	logic [NODE_ID_BITS-1:0] src1, src2, dst1, dst2;
	logic [3:0]              flit_index;
	logic [DATA_W-1:0]       data_in;
	logic                    accept;

	assign coded      = s_axis_tuser[0];
	assign head       = s_axis_tuser[1];
	assign tail       = s_axis_tlast;
	assign src1       = s_axis_tdata[7:0];
	assign src2       = s_axis_tdata[15:8];
	assign dst1       = s_axis_tdata[23:16];
	assign dst2       = s_axis_tdata[31:24];
	assign flit_index = s_axis_tdata[35:32];
	assign data_in    = s_axis_tdata[36 +: DATA_W];

	// ---------------- packet table (flops, compared in parallel) ----------------
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]         keys_q   [TABLE_ENTRIES];
	logic [SLOT_W-1:0]        rank_q   [TABLE_ENTRIES];
	logic [LEN_W-1:0]         length_q [TABLE_ENTRIES];
	logic                     match_act_q, fill_act_q;
	logic [SLOT_W-1:0]        match_slot_q, fill_slot_q;

	logic              state_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] payload_s1;
	logic              use_ram_s1, decoded_s1, stored_s1;
	logic [1:0]        err_s1;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TUSER_W-1:0] out_user_q;

	logic [KEY_W-1:0] want_key, own_key;
	assign want_key = {dst2, dst1, src1, src2};   // sources swapped
	assign own_key  = {dst2, dst1, src2, src1};

	// oldest matching entry
	logic              hit;
	logic [SLOT_W-1:0] best;
	always_comb begin
		hit  = 1'b0;
		best = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (valid_q[i] && keys_q[i] == want_key && (!hit || rank_q[i] < rank_q[best])) begin
				hit  = 1'b1;
				best = SLOT_W'(i);
			end
		end
	end

	// lowest free entry and occupancy
	logic              found;
	logic [SLOT_W-1:0] free_idx;
	logic [CNT_W-1:0]  count;
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		count    = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (valid_q[i]) begin
				count = count + CNT_W'(1);
			end else if (!found) begin
				found    = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	// ---------------- per-flit decision ----------------
	logic              nm_act, nf_act;
	logic [SLOT_W-1:0] nm_slot, nf_slot;
	logic              do_read, do_write, do_alloc, do_append, do_free;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic              dec, sto;
	logic [1:0]        err;
	logic [LEN_W-1:0]  idx_ext, match_len, fill_len;

	assign idx_ext   = LEN_W'(flit_index);
	assign match_len = length_q[match_slot_q];
	assign fill_len  = length_q[fill_slot_q];

	always_comb begin
		nm_act    = match_act_q;
		nm_slot   = match_slot_q;
		nf_act    = fill_act_q;
		nf_slot   = fill_slot_q;
		do_read   = 1'b0;
		do_write  = 1'b0;
		do_alloc  = 1'b0;
		do_append = 1'b0;
		do_free   = 1'b0;
		rd_addr   = '0;
		wr_addr   = '0;
		dec       = 1'b0;
		sto       = 1'b0;
		err       = ERR_NONE;
		if (coded) begin
			if (head) begin
				nm_act = 1'b0;
				nf_act = 1'b0;
				if (hit) begin
					do_read = 1'b1;
					rd_addr = ADDR_W'(best * MAX_FLITS);
					dec     = 1'b1;
					nm_act  = 1'b1;
					nm_slot = best;
				end else if (found) begin
					do_alloc = 1'b1;
					do_write = 1'b1;
					wr_addr  = ADDR_W'(free_idx * MAX_FLITS);
					sto      = 1'b1;
					nf_act   = 1'b1;
					nf_slot  = free_idx;
				end else begin
					err = ERR_FULL;
				end
			end else begin
				if (match_act_q) begin
					if (idx_ext < match_len && idx_ext < LEN_W'(MAX_FLITS)) begin
						do_read = 1'b1;
						rd_addr = ADDR_W'(match_slot_q * MAX_FLITS) + ADDR_W'(flit_index);
						dec     = 1'b1;
					end else begin
						err = ERR_BEYOND;
					end
				end else if (fill_act_q) begin
					if (fill_len < LEN_W'(MAX_FLITS)) begin
						do_append = 1'b1;
						do_write  = 1'b1;
						wr_addr   = ADDR_W'(fill_slot_q * MAX_FLITS) + ADDR_W'(fill_len);
						sto       = 1'b1;
					end else begin
						err = ERR_NO_ENTRY;
					end
				end else begin
					err = ERR_NO_ENTRY;
				end
			end
			if (tail) begin
				do_free = nm_act && valid_q[nm_slot];
				nm_act  = 1'b0;
				nf_act  = 1'b0;
			end
		end
	end

	// ---------------- handshake and sequencing ----------------
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	logic              out_free;
	logic [DATA_W-1:0] ram_rdata, result;
	assign out_free = !out_valid_q || m_axis_tready;
	assign result   = use_ram_s1 ? (payload_s1 ^ ram_rdata) : payload_s1;

	ncxd_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (accept && do_write),
		.waddr(wr_addr),
		.wdata(data_in),
		.re   (accept && do_read),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// table and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			match_act_q  <= 1'b0;
			match_slot_q <= '0;
			fill_act_q   <= 1'b0;
			fill_slot_q  <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				rank_q[i]   <= '0;
				length_q[i] <= '0;
			end
		end else if (accept) begin
			match_act_q  <= nm_act;
			match_slot_q <= nm_slot;
			fill_act_q   <= nf_act;
			fill_slot_q  <= nf_slot;
			if (do_alloc) begin
				valid_q[free_idx]  <= 1'b1;
				rank_q[free_idx]   <= count[SLOT_W-1:0];
				length_q[free_idx] <= LEN_W'(1);
			end
			if (do_append) begin
				length_q[fill_slot_q] <= fill_len + LEN_W'(1);
			end
			if (do_free) begin
				// younger entries move up one rank
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (valid_q[i] && rank_q[i] > rank_q[nm_slot]) begin
						rank_q[i] <= rank_q[i] - SLOT_W'(1);
					end
				end
				valid_q[nm_slot]  <= 1'b0;
				length_q[nm_slot] <= '0;
				rank_q[nm_slot]   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && do_alloc) begin
			keys_q[free_idx] <= own_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_READ: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// stage one: flit and decision wait for the RAM read
	always_ff @(posedge clk) begin
		if (accept) begin
			payload_s1 <= data_in;
			use_ram_s1 <= do_read;
			decoded_s1 <= dec;
			stored_s1  <= sto;
			err_s1     <= err;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (state_q == ST_READ && out_free) begin
			out_data_q <= OUT_TDATA_W'(result);
			out_user_q <= {err_s1, stored_s1, decoded_s1};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

[design/ncxd_ram.sv]
module ncxd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/ncxd_checker.sv]
`include "network_coded_xor_decoder_top_assert.svh"

module ncxd_sva
	import ncxd_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [IN_TUSER_W-1:0]  s_axis_tuser,
	input logic                   s_axis_tlast,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	// a stalled result word holds
	`NCXD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// one flit in flight: no accept in the cycle after an accept
	`NCXD_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// a word is never both decoded and stored
	`NCXD_ASSERT_IMP(a_dec_xor_sto, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))

	// an error word carries neither flag
	`NCXD_ASSERT_IMP(a_err_no_flags, m_axis_tvalid && m_axis_tuser[3:2] != ERR_NONE, m_axis_tuser[1:0] == 2'b00)

endmodule

bind network_coded_xor_decoder_top ncxd_sva u_ncxd_sva (.*);
